FILE: rtl/utf8_decode_char_classify_macros.svh
// Assertion macros used by the checker file of the decoder.
`ifndef UTF8_DECODE_CHAR_CLASSIFY_MACROS_SVH
`define UTF8_DECODE_CHAR_CLASSIFY_MACROS_SVH

// Plain property, sampled on clk and held off while reset is asserted.
`define U8D_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define U8D_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define U8D_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/utf8d_pkg.sv
package utf8d_pkg;

	// Longest sequence form accepted; legal range is 4 to 6.
	localparam int MAX_SEQ_BYTES = 6;

	localparam int CP_W        = 31;
	localparam int CONT_BITS   = 6;
	localparam int SPACE_COUNT = 25;

	localparam logic [CP_W-1:0] CP_MONGOLIAN_VS = 31'h0000180E;
	localparam logic [CP_W-1:0] CP_WIDE_LIMIT   = 31'h00000080;

	// Script whitespace code points.
	localparam logic [CP_W-1:0] SPACE_LIST [SPACE_COUNT] = '{
		31'h09, 31'h0A, 31'h0B, 31'h0C, 31'h0D, 31'h20, 31'hA0, 31'h1680,
		31'h2000, 31'h2001, 31'h2002, 31'h2003, 31'h2004, 31'h2005, 31'h2006,
		31'h2007, 31'h2008, 31'h2009, 31'h200A, 31'h2028, 31'h2029, 31'h202F,
		31'h205F, 31'h3000, 31'hFEFF
	};

	// One decoded character as it travels from the front end to the back end.
	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            bad_lead;
	} char_t;

	// Number of leading one bits of a byte.
	function automatic logic [3:0] lead_ones(input logic [7:0] b);
		logic [3:0] n;
		logic       run;
		n   = '0;
		run = 1'b1;
		for (int i = 7; i >= 0; i--) begin
			if (run && b[i]) begin
				n = n + 4'd1;
			end else begin
				run = 1'b0;
			end
		end
		return n;
	endfunction

	// Payload bits kept for a sequence of the given length.
	function automatic logic [CP_W-1:0] payload_mask(input logic [2:0] len);
		logic [CP_W-1:0] m;
		case (len)
			3'd1: m = 31'h0000007F;
			3'd2: m = 31'h000007FF;
			3'd3: m = 31'h0000FFFF;
			3'd4: m = 31'h001FFFFF;
			3'd5: m = 31'h03FFFFFF;
			3'd6: m = 31'h7FFFFFFF;
			default: m = '0;
		endcase
		return m;
	endfunction

	// True when the code point is in the whitespace list.
	function automatic logic is_space_cp(input logic [CP_W-1:0] cp);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < SPACE_COUNT; i++) begin
			if (cp == SPACE_LIST[i]) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

FILE: rtl/utf8_decode_char_classify.sv
// Byte-serial UTF-8 decoder (original form, up to six bytes, no continuation
// check, overlong forms accepted) that classifies each finished character as
// script whitespace, identifier start and identifier part. One byte is taken
// per clock cycle, sustained; in_stall rises only when the two-entry queue
// between the decoding front end and the classifying output stage is full,
// which happens only while out_stall holds results back. A character's result
// is written into the queue with the transfer of its last byte and is then
// moved into the output register, from which it is offered at the output. A
// bad lead byte gives code point 0 with bad_lead set. There is no start-up
// delay after reset.
module utf8_decode_char_classify (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 byte_in,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [utf8d_pkg::CP_W-1:0] code_point,
	output logic                       is_space,
	output logic                       ident_start,
	output logic                       ident_part,
	output logic                       bad_lead
);

	logic             accept;
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_not_empty;
	utf8d_pkg::char_t push_data;
	utf8d_pkg::char_t pop_data;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// Front end: sequence tracking and code point assembly.
	utf8d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.byte_in   (byte_in),
		.push      (push),
		.push_data (push_data)
	);

	// Decoupling queue between front and back.
	utf8d_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	// Back end: classification and output register.
	utf8d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_data      (pop_data),
		.q_pop       (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.code_point  (code_point),
		.is_space    (is_space),
		.ident_start (ident_start),
		.ident_part  (ident_part),
		.bad_lead    (bad_lead)
	);

endmodule

FILE: rtl/utf8d_queue.sv
module utf8d_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  utf8d_pkg::char_t push_data,
	input  logic             pop,
	output utf8d_pkg::char_t pop_data,
	output logic             not_empty,
	output logic             full
);

	utf8d_pkg::char_t entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign not_empty = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign pop_data  = entry_q[rd_ptr_q];

	// Entry storage; written only on a push.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: rtl/utf8d_front.sv
module utf8d_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       byte_in,
	output logic             push,
	output utf8d_pkg::char_t push_data
);

	logic [2:0]                 bytes_left_q;
	logic [2:0]                 seq_len_q;
	logic [utf8d_pkg::CP_W-1:0] code_acc_q;

	logic [3:0]                 ones;
	logic [utf8d_pkg::CP_W-1:0] acc_shift;
	logic [utf8d_pkg::CP_W-1:0] byte_cp;
	logic                       in_seq;
	logic                       lead_bad;

	assign ones      = utf8d_pkg::lead_ones(byte_in);
	assign acc_shift = {code_acc_q[utf8d_pkg::CP_W-utf8d_pkg::CONT_BITS-1:0],
		byte_in[utf8d_pkg::CONT_BITS-1:0]};
	assign byte_cp   = {{(utf8d_pkg::CP_W-8){1'b0}}, byte_in};
	assign in_seq    = (bytes_left_q != 3'd0);
	assign lead_bad  = (ones == 4'd1) || (ones > 4'(utf8d_pkg::MAX_SEQ_BYTES));

	// A character completes on the last continuation byte, an ASCII byte or a bad lead.
	always_comb begin
		push_data.code_point = byte_cp;
		push_data.bad_lead   = 1'b0;
		push                 = 1'b0;
		if (in_seq) begin
			push_data.code_point = acc_shift & utf8d_pkg::payload_mask(seq_len_q);
			push                 = accept && (bytes_left_q == 3'd1);
		end else if (ones == 4'd0) begin
			push = accept;
		end else if (lead_bad) begin
			push_data.code_point = '0;
			push_data.bad_lead   = 1'b1;
			push                 = accept;
		end
	end

	// Sequence state: count of bytes still to come and the partial value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= 3'd0;
			seq_len_q    <= 3'd0;
			code_acc_q   <= '0;
		end else if (accept) begin
			if (in_seq) begin
				bytes_left_q <= bytes_left_q - 3'd1;
				if (bytes_left_q == 3'd1) begin
					seq_len_q  <= 3'd0;
					code_acc_q <= '0;
				end else begin
					code_acc_q <= acc_shift;
				end
			end else if (ones != 4'd0 && !lead_bad) begin
				seq_len_q    <= ones[2:0];
				bytes_left_q <= ones[2:0] - 3'd1;
				code_acc_q   <= byte_cp;
			end
		end
	end

endmodule

FILE: rtl/utf8d_back.sv
module utf8d_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_not_empty,
	input  utf8d_pkg::char_t           q_data,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [utf8d_pkg::CP_W-1:0] code_point,
	output logic                       is_space,
	output logic                       ident_start,
	output logic                       ident_part,
	output logic                       bad_lead
);

	logic                       valid_q;
	logic [utf8d_pkg::CP_W-1:0] code_point_q;
	logic                       is_space_q;
	logic                       ident_start_q;
	logic                       ident_part_q;
	logic                       bad_lead_q;

	logic                       sp;
	logic                       alpha;
	logic                       digit;
	logic                       start;
	logic [utf8d_pkg::CP_W-1:0] cp;

	assign cp    = q_data.code_point;
	assign q_pop = q_not_empty && (!valid_q || !out_stall);

	// Character classes of the code point at the head of the queue.
	always_comb begin
		sp    = utf8d_pkg::is_space_cp(cp);
		alpha = (cp >= 31'h41 && cp <= 31'h5A) || (cp >= 31'h61 && cp <= 31'h7A) ||
			(cp == 31'h24) || (cp == 31'h5F);
		digit = (cp >= 31'h30 && cp <= 31'h39);
		start = alpha || ((cp > utf8d_pkg::CP_WIDE_LIMIT) && !sp &&
			(cp != utf8d_pkg::CP_MONGOLIAN_VS));
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !out_stall) begin
			valid_q <= q_not_empty;
		end
	end

	// Output register payload, loaded on every transfer out of the queue.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			code_point_q  <= cp;
			is_space_q    <= sp;
			ident_start_q <= start;
			ident_part_q  <= start || digit;
			bad_lead_q    <= q_data.bad_lead;
		end
	end

	assign out_valid   = valid_q;
	assign code_point  = code_point_q;
	assign is_space    = is_space_q;
	assign ident_start = ident_start_q;
	assign ident_part  = ident_part_q;
	assign bad_lead    = bad_lead_q;

endmodule

FILE: rtl/utf8d_checker.sv
`include "utf8_decode_char_classify_macros.svh"

module utf8d_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic [7:0]                 byte_in,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [utf8d_pkg::CP_W-1:0] code_point,
	input logic                       is_space,
	input logic                       ident_start,
	input logic                       ident_part,
	input logic                       bad_lead
);

	// A stalled input byte stays offered and unchanged.
	`U8D_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(byte_in),
		"stalled input byte changed")

	// A held result stays offered.
	`U8D_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

	// A bad lead carries code point 0 and no class.
	`U8D_ASSERT_IMPL(a_bad_zero, out_valid && bad_lead,
		(code_point == '0) && !is_space && !ident_start && !ident_part,
		"bad lead with nonzero value or class")

	// Every identifier start may also continue an identifier.
	`U8D_ASSERT_IMPL(a_start_part, out_valid && ident_start, ident_part,
		"identifier start without part")

	// Whitespace never counts as an identifier character.
	`U8D_ASSERT_IMPL(a_space_ident, out_valid && is_space, !ident_part,
		"whitespace classed as identifier")

endmodule

bind utf8_decode_char_classify utf8d_checker u_checker (.*);
